// ----- design/segregated_block_pool_allocator_macros.svh -----
// Assertion macros for the segregated block pool allocator.
// Included by the top level; no other dependencies.
`ifndef SEGREGATED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define SEGREGATED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define SBPA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sbpa assertion failed");
// next-cycle implication
`define SBPA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sbpa assertion failed");
`else
`define SBPA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SBPA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- design/sbpa_pkg.sv -----
// Shared types, codes and defaults of the segregated block pool allocator.
// No dependencies; imported by the controller, datapath and top level.
package sbpa_pkg;

   // default pool depths
   localparam int SBPA_SMALL_BLOCKS  = 64;
   localparam int SBPA_MEDIUM_BLOCKS = 64;
   localparam int SBPA_LARGE_BLOCKS  = 64;

   // field widths
   localparam int SIZE_W     = 24;
   localparam int BADDR_W    = 32;
   localparam int HDR_W      = 8;
   localparam int OUT_IDX_W  = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // commands
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // size classes
   localparam logic [1:0] CLASS_SMALL  = 2'd0;
   localparam logic [1:0] CLASS_MEDIUM = 2'd1;
   localparam logic [1:0] CLASS_LARGE  = 2'd2;
   localparam logic [1:0] CLASS_NULL   = 2'd3;

   // result status codes
   localparam logic [2:0] STATUS_GRANTED   = 3'd0;
   localparam logic [2:0] STATUS_TOO_LARGE = 3'd1;
   localparam logic [2:0] STATUS_EXHAUSTED = 3'd2;
   localparam logic [2:0] STATUS_FREED     = 3'd3;
   localparam logic [2:0] STATUS_IGNORED   = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SMALL_SIZE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEDIUM_SIZE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LARGE_SIZE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SMALL_END   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MEDIUM_END  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LARGE_END   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER      = 3'd6;

   // register reset values
   localparam logic [SIZE_W-1:0]  SMALL_SIZE_RST  = 24'd64;
   localparam logic [SIZE_W-1:0]  MEDIUM_SIZE_RST = 24'd256;
   localparam logic [SIZE_W-1:0]  LARGE_SIZE_RST  = 24'd1024;
   localparam logic [BADDR_W-1:0] REGION_END_RST  = 32'd0;
   localparam logic [HDR_W-1:0]   HEADER_RST      = 8'd16;

   typedef struct packed {
      logic              cmd;
      logic [SIZE_W-1:0] request_size;
      logic [1:0]        free_class;
      logic [5:0]        free_index;
   } req_type;

   typedef struct packed {
      logic [2:0]           status;
      logic [1:0]           block_class;
      logic [OUT_IDX_W-1:0] block_index;
      logic [BADDR_W-1:0]   body_address;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic init_step;
      logic load_req;
      logic check;
      logic update;
      logic link;
      logic addr;
      logic load_rsp;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic init_last;
      logic is_free;
      logic reject;
      logic dup_free;
   } dp_stat_type;

endpackage

// ----- design/sbpa_ctrl.sv -----
// Controller state machine of the segregated block pool allocator.
// Depends on sbpa_pkg; drives the datapath through dp_cmd_type.
module sbpa_ctrl
   import sbpa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_INIT, ST_IDLE, ST_CHECK, ST_UPDATE, ST_LINK, ST_ADDR, ST_SEND
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free, accept;

   // output slot can take a new result this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) || ((state_ff == ST_SEND) && out_free));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   // datapath commands
   always_comb begin
      cmd           = '0;
      cmd.init_step = (state_ff == ST_INIT);
      cmd.load_req  = accept;
      cmd.check     = (state_ff == ST_CHECK);
      cmd.update    = (state_ff == ST_UPDATE);
      cmd.link      = (state_ff == ST_LINK);
      cmd.addr      = (state_ff == ST_ADDR);
      cmd.load_rsp  = (state_ff == ST_SEND) && out_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT:   if (stat.init_last) state_in = ST_IDLE;
         ST_IDLE:   if (accept) state_in = ST_CHECK;
         ST_CHECK:  state_in = stat.reject ? ST_SEND : ST_UPDATE;
         ST_UPDATE: begin
            if (!stat.is_free) state_in = ST_ADDR;
            else if (stat.dup_free) state_in = ST_SEND;
            else state_in = ST_LINK;
         end
         ST_LINK:   state_in = ST_SEND;
         ST_ADDR:   state_in = ST_SEND;
         ST_SEND:   if (out_free) state_in = accept ? ST_CHECK : ST_IDLE;
         default:   state_in = ST_INIT;
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- design/sbpa_dpath.sv -----
// Datapath of the segregated block pool allocator: registers, free-ring
// link memories, allocated marks and address arithmetic. Depends on sbpa_pkg.
module sbpa_dpath
   import sbpa_pkg::*;
#(
   parameter int SMALL_BLOCKS  = SBPA_SMALL_BLOCKS,
   parameter int MEDIUM_BLOCKS = SBPA_MEDIUM_BLOCKS,
   parameter int LARGE_BLOCKS  = SBPA_LARGE_BLOCKS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_stat_type           stat,
   input  req_type               req_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output rsp_type               rsp_payload
);

   localparam int TOTAL_BLOCKS = SMALL_BLOCKS + MEDIUM_BLOCKS + LARGE_BLOCKS;
   localparam int MAX_SM       = (SMALL_BLOCKS > MEDIUM_BLOCKS) ? SMALL_BLOCKS : MEDIUM_BLOCKS;
   localparam int MAX_BLOCKS   = (MAX_SM > LARGE_BLOCKS) ? MAX_SM : LARGE_BLOCKS;
   localparam int IDX_W        = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int ADDR_W       = $clog2(TOTAL_BLOCKS);
   localparam int PROD_W       = IDX_W + 1 + SIZE_W;

   localparam logic [ADDR_W-1:0] MED_BASE   = ADDR_W'(SMALL_BLOCKS);
   localparam logic [ADDR_W-1:0] LRG_BASE   = ADDR_W'(SMALL_BLOCKS + MEDIUM_BLOCKS);
   localparam logic [IDX_W-1:0]  SMALL_LAST = IDX_W'(SMALL_BLOCKS - 1);
   localparam logic [IDX_W-1:0]  MED_LAST   = IDX_W'(MEDIUM_BLOCKS - 1);
   localparam logic [IDX_W-1:0]  LRG_LAST   = IDX_W'(LARGE_BLOCKS - 1);

   function automatic logic [ADDR_W-1:0] class_base(input logic [1:0] c);
      logic [ADDR_W-1:0] b;
      case (c)
         CLASS_SMALL:  b = '0;
         CLASS_MEDIUM: b = MED_BASE;
         default:      b = LRG_BASE;
      endcase
      return b;
   endfunction

   function automatic logic [IDX_W-1:0] class_last(input logic [1:0] c);
      logic [IDX_W-1:0] l;
      case (c)
         CLASS_SMALL:  l = SMALL_LAST;
         CLASS_MEDIUM: l = MED_LAST;
         default:      l = LRG_LAST;
      endcase
      return l;
   endfunction

   function automatic logic [31:0] class_count(input logic [1:0] c);
      logic [31:0] n;
      case (c)
         CLASS_SMALL:  n = 32'(SMALL_BLOCKS);
         CLASS_MEDIUM: n = 32'(MEDIUM_BLOCKS);
         default:      n = 32'(LARGE_BLOCKS);
      endcase
      return n;
   endfunction

   // configuration registers
   logic [SIZE_W-1:0]  small_size_ff, medium_size_ff, large_size_ff;
   logic [BADDR_W-1:0] small_end_ff, medium_end_ff, large_end_ff;
   logic [HDR_W-1:0]   hdr_ff;

   // ring heads and empty flags
   logic [IDX_W-1:0] head_ff [3];
   logic [2:0]       empty_ff;

   // clearing pass counters
   logic [1:0]        init_cls_ff;
   logic [IDX_W-1:0]  init_idx_ff;
   logic [ADDR_W-1:0] init_addr_ff;

   // link and mark memories
   logic [IDX_W-1:0] next_mem [TOTAL_BLOCKS];
   logic [IDX_W-1:0] prev_mem [TOTAL_BLOCKS];
   logic             mark_mem [TOTAL_BLOCKS];
   logic [IDX_W-1:0] next_rd_ff, prev_rd_ff;
   logic             mark_rd_ff;

   // per-request registers
   req_type            req_ff;
   logic [1:0]         cls_ff;
   logic [IDX_W-1:0]   h_ff, f_ff;
   logic               was_empty_ff;
   logic [BADDR_W-1:0] prod_ff;
   rsp_type            res_ff, rsp_ff;

   // check-stage logic
   logic [SIZE_W:0]    total;
   logic               too_large, free_ok, is_free, op_empty;
   logic [1:0]         sel_cls, op_cls;
   logic [IDX_W-1:0]   op_head, op_fidx;
   logic [ADDR_W-1:0]  rd_addr, mark_rd_addr;
   logic [2:0]         rej_status;

   // update-stage logic
   logic [ADDR_W-1:0]  cls_base;
   logic [SIZE_W-1:0]  size_sel;
   logic [BADDR_W-1:0] end_sel;
   logic [IDX_W:0]     h_inc;
   logic [PROD_W-1:0]  prod_full;
   logic [BADDR_W-1:0] body;

   // memory write ports
   logic              next_we, prev_we, mark_we;
   logic [ADDR_W-1:0] next_wa, prev_wa, mark_wa;
   logic [IDX_W-1:0]  next_wd, prev_wd;
   logic              mark_wd;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         small_size_ff  <= SMALL_SIZE_RST;
         medium_size_ff <= MEDIUM_SIZE_RST;
         large_size_ff  <= LARGE_SIZE_RST;
         small_end_ff   <= REGION_END_RST;
         medium_end_ff  <= REGION_END_RST;
         large_end_ff   <= REGION_END_RST;
         hdr_ff         <= HEADER_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SMALL_SIZE:  small_size_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_MEDIUM_SIZE: medium_size_ff <= csr_wdata[SIZE_W-1:0];
            CSR_LARGE_SIZE:  large_size_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_SMALL_END:   small_end_ff   <= csr_wdata[BADDR_W-1:0];
            CSR_MEDIUM_END:  medium_end_ff  <= csr_wdata[BADDR_W-1:0];
            CSR_LARGE_END:   large_end_ff   <= csr_wdata[BADDR_W-1:0];
            CSR_HEADER:      hdr_ff         <= csr_wdata[HDR_W-1:0];
            default: ;
         endcase
      end
   end

   // class choice and rejection, from the latched request
   always_comb begin
      is_free = (req_ff.cmd == CMD_FREE);
      total   = {1'b0, req_ff.request_size} + (SIZE_W+1)'(hdr_ff);
      too_large = 1'b0;
      if (total <= {1'b0, small_size_ff}) sel_cls = CLASS_SMALL;
      else if (total <= {1'b0, medium_size_ff}) sel_cls = CLASS_MEDIUM;
      else if (total <= {1'b0, large_size_ff}) sel_cls = CLASS_LARGE;
      else begin
         sel_cls   = CLASS_LARGE;
         too_large = 1'b1;
      end
      free_ok = (req_ff.free_class != CLASS_NULL) &&
                (32'(req_ff.free_index) < class_count(req_ff.free_class));
      op_cls  = is_free ? req_ff.free_class : sel_cls;
      case (op_cls)
         CLASS_SMALL:  begin op_head = head_ff[0]; op_empty = empty_ff[0]; end
         CLASS_MEDIUM: begin op_head = head_ff[1]; op_empty = empty_ff[1]; end
         default:      begin op_head = head_ff[2]; op_empty = empty_ff[2]; end
      endcase
      op_fidx      = IDX_W'(req_ff.free_index);
      rd_addr      = class_base(op_cls) + ADDR_W'(op_head);
      mark_rd_addr = class_base(op_cls) + ADDR_W'(op_fidx);
      if (is_free) rej_status = STATUS_IGNORED;
      else if (too_large) rej_status = STATUS_TOO_LARGE;
      else rej_status = STATUS_EXHAUSTED;
   end

   assign stat.init_last = (init_cls_ff == CLASS_LARGE) && (init_idx_ff == LRG_LAST);
   assign stat.is_free   = is_free;
   assign stat.reject    = is_free ? !free_ok : (too_large || op_empty);
   assign stat.dup_free  = is_free && !mark_rd_ff;

   // class-dependent operands of the latched request
   always_comb begin
      cls_base = class_base(cls_ff);
      case (cls_ff)
         CLASS_SMALL:  begin size_sel = small_size_ff;  end_sel = small_end_ff;  end
         CLASS_MEDIUM: begin size_sel = medium_size_ff; end_sel = medium_end_ff; end
         default:      begin size_sel = large_size_ff;  end_sel = large_end_ff;  end
      endcase
      h_inc     = {1'b0, h_ff} + (IDX_W+1)'(1);
      prod_full = PROD_W'(h_inc) * PROD_W'(size_sel);
      body      = end_sel - prod_ff + BADDR_W'(hdr_ff);
   end

   // memory write port selection
   always_comb begin
      next_we = 1'b0; next_wa = '0; next_wd = '0;
      prev_we = 1'b0; prev_wa = '0; prev_wd = '0;
      mark_we = 1'b0; mark_wa = '0; mark_wd = 1'b0;
      if (cmd.init_step) begin
         // ring in index order, marks clear
         next_we = 1'b1;
         next_wa = init_addr_ff;
         next_wd = (init_idx_ff == class_last(init_cls_ff)) ? '0
                                                             : init_idx_ff + IDX_W'(1);
         prev_we = 1'b1;
         prev_wa = init_addr_ff;
         prev_wd = (init_idx_ff == '0) ? class_last(init_cls_ff)
                                       : init_idx_ff - IDX_W'(1);
         mark_we = 1'b1;
         mark_wa = init_addr_ff;
      end else if (cmd.update && !is_free) begin
         // unlink the head unless it was the last free block
         if (next_rd_ff != h_ff) begin
            prev_we = 1'b1;
            prev_wa = cls_base + ADDR_W'(next_rd_ff);
            prev_wd = prev_rd_ff;
            next_we = 1'b1;
            next_wa = cls_base + ADDR_W'(prev_rd_ff);
            next_wd = next_rd_ff;
         end
         mark_we = 1'b1;
         mark_wa = cls_base + ADDR_W'(h_ff);
         mark_wd = 1'b1;
      end else if (cmd.update && mark_rd_ff) begin
         mark_we = 1'b1;
         mark_wa = cls_base + ADDR_W'(f_ff);
         next_we = 1'b1;
         prev_we = 1'b1;
         if (was_empty_ff) begin
            // freed block forms a ring of its own
            next_wa = cls_base + ADDR_W'(f_ff);
            next_wd = f_ff;
            prev_wa = cls_base + ADDR_W'(f_ff);
            prev_wd = f_ff;
         end else begin
            // head and its successor point at the freed block
            next_wa = cls_base + ADDR_W'(h_ff);
            next_wd = f_ff;
            prev_wa = cls_base + ADDR_W'(next_rd_ff);
            prev_wd = f_ff;
         end
      end else if (cmd.link && !was_empty_ff) begin
         // freed block points back at head and on to successor
         next_we = 1'b1;
         next_wa = cls_base + ADDR_W'(f_ff);
         next_wd = next_rd_ff;
         prev_we = 1'b1;
         prev_wa = cls_base + ADDR_W'(f_ff);
         prev_wd = h_ff;
      end
   end

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (next_we) next_mem[next_wa] <= next_wd;
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      if (mark_we) mark_mem[mark_wa] <= mark_wd;
      if (cmd.check) begin
         next_rd_ff <= next_mem[rd_addr];
         prev_rd_ff <= prev_mem[rd_addr];
         mark_rd_ff <= mark_mem[mark_rd_addr];
      end
   end

   // clearing pass walk, ring heads and empty flags
   always_ff @(posedge clock) begin
      if (reset) begin
         init_cls_ff  <= CLASS_SMALL;
         init_idx_ff  <= '0;
         init_addr_ff <= '0;
         head_ff      <= '{default: '0};
         empty_ff     <= '0;
      end else begin
         if (cmd.init_step && !stat.init_last) begin
            init_addr_ff <= init_addr_ff + ADDR_W'(1);
            if (init_idx_ff == class_last(init_cls_ff)) begin
               init_idx_ff <= '0;
               init_cls_ff <= init_cls_ff + 2'd1;
            end else begin
               init_idx_ff <= init_idx_ff + IDX_W'(1);
            end
         end
         for (int k = 0; k < 3; k++) begin
            if (cls_ff == 2'(k)) begin
               if (cmd.update && !is_free) begin
                  if (next_rd_ff == h_ff) empty_ff[k] <= 1'b1;
                  else head_ff[k] <= next_rd_ff;
               end else if (cmd.update && mark_rd_ff) begin
                  head_ff[k]  <= f_ff;
                  empty_ff[k] <= 1'b0;
               end
            end
         end
      end
   end

   // request capture, check snapshot, multiply and results
   always_ff @(posedge clock) begin
      if (cmd.load_req) req_ff <= req_payload;
      if (cmd.check) begin
         cls_ff       <= op_cls;
         h_ff         <= op_head;
         f_ff         <= op_fidx;
         was_empty_ff <= op_empty;
         if (stat.reject) res_ff <= '{status: rej_status, default: '0};
      end
      if (cmd.update) begin
         prod_ff <= BADDR_W'(prod_full);
         if (stat.dup_free) res_ff <= '{status: STATUS_IGNORED, default: '0};
      end
      if (cmd.link) res_ff <= '{status: STATUS_FREED, default: '0};
      if (cmd.addr) begin
         res_ff.status       <= STATUS_GRANTED;
         res_ff.block_class  <= cls_ff;
         res_ff.block_index  <= OUT_IDX_W'(h_ff);
         res_ff.body_address <= body;
      end
      if (cmd.load_rsp) rsp_ff <= res_ff;
   end

   assign rsp_payload = rsp_ff;

endmodule

// ----- design/segregated_block_pool_allocator.sv -----
// Top level of the segregated block pool allocator.
// Uses sbpa_pkg, sbpa_ctrl, sbpa_dpath and the assertion macro header.
//
// Usage: allocate or free requests enter on req_valid/req_stall/req_payload
// and each produces exactly one result on rsp_valid/rsp_stall/rsp_payload.
// An allocate picks the smallest class whose block holds request_size plus
// the header and returns class, index and body address; a free links the
// named block back into its class ring. Registers are written on
// csr_valid/csr_ready (always ready) with csr_index and csr_wdata. The
// user must write them only while no request is in flight (not enforced).
// Sequence: each request walks the check, memory update and then address or
// relink states before send; rejected requests go from check straight to send
// and ignored double frees from update to send. The next request is taken in
// the cycle the result moves to the output register, so a new request is not
// taken before the current result has moved there.
// Reset: after reset a clearing pass writes the rings, one block per cycle,
// SMALL_BLOCKS + MEDIUM_BLOCKS + LARGE_BLOCKS blocks in all, with req_stall high.
// A stalled result holds in the output register; one more request is then
// processed and waits until the output register frees before req_stall drops.
`include "segregated_block_pool_allocator_macros.svh"

module segregated_block_pool_allocator
   import sbpa_pkg::*;
#(
   parameter int SMALL_BLOCKS  = SBPA_SMALL_BLOCKS,
   parameter int MEDIUM_BLOCKS = SBPA_MEDIUM_BLOCKS,
   parameter int LARGE_BLOCKS  = SBPA_LARGE_BLOCKS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;
   logic [4:0]  dp_phase;

   assign csr_ready = 1'b1;

   sbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   sbpa_dpath #(
      .SMALL_BLOCKS  (SMALL_BLOCKS),
      .MEDIUM_BLOCKS (MEDIUM_BLOCKS),
      .LARGE_BLOCKS  (LARGE_BLOCKS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (dp_cmd),
      .stat        (dp_stat),
      .req_payload (req_payload),
      .csr_we      (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_payload (rsp_payload)
   );

   // at most one datapath step per cycle
   assign dp_phase = {dp_cmd.init_step, dp_cmd.check, dp_cmd.update, dp_cmd.link, dp_cmd.addr};

   `SBPA_ASSERT_IMP(a_rsp_no_overwrite, clock, reset, dp_cmd.load_rsp, (!rsp_valid || !rsp_stall))
   `SBPA_ASSERT_NEXT(a_accept_then_check, clock, reset, (req_valid && !req_stall), dp_cmd.check)
   `SBPA_ASSERT_IMP(a_single_phase, clock, reset, 1'b1, $onehot0(dp_phase))
   `SBPA_ASSERT_NEXT(a_dup_free_no_link, clock, reset, (dp_cmd.update && dp_stat.dup_free), !dp_cmd.link)

endmodule
